[rtl/blake2b_unkeyed_hash_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLAKE2B_UNKEYED_HASH_CORE_DEFINES_SVH
`define BLAKE2B_UNKEYED_HASH_CORE_DEFINES_SVH
// Asserts a property on the rising clock edge, held off while reset is low.
`define B2B_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Asserts a property on the rising clock edge, checked during reset too.
`define B2B_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/b2b_pkg.sv]
`timescale 1ns / 1ps
package b2b_pkg;
    localparam int BLOCK_BYTES = 128;
    localparam int ROUND_COUNT = 12;
    localparam int BLOCK_WORDS = BLOCK_BYTES / 8;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    localparam logic [31:0] PARAM_WORD = 32'h01010000;

    // Message schedule: ten rows of sixteen 4-bit word indexes, row r at [r].
    localparam logic [63:0] SIGMA [10] = '{
        64'hfedcba9876543210, 64'h357b20c16df984ae,
        64'h491763eadf250c8b, 64'h8f04a562ebcd1397,
        64'hd386cb1efa427509, 64'h91ef57d438b0a6c2,
        64'hb8293670a4def15c, 64'ha2684f05931ce7bd,
        64'h5a417d2c803b9ef6, 64'h0dc3e9bf5167482a
    };

    typedef enum logic [1:0] {
        CMD_NONE, CMD_INIT, CMD_LOAD, CMD_STEP
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       final_blk;
        logic [3:0] round;
        logic       diag;
        logic       finish;
    } t_dp_ctrl;

    function automatic logic [3:0] sigma_at(input logic [3:0] r, input logic [3:0] j);
        logic [63:0] row;
        row = SIGMA[(r >= 4'd10) ? r - 4'd10 : r];
        return row[j*4 +: 4];
    endfunction

    function automatic logic [6:0] eff_len(input logic [6:0] d);
        if (d == 7'd0) return 7'd1;
        if (d > 7'd64) return 7'd64;
        return d;
    endfunction
endpackage

[rtl/b2b_datapath.sv]
`timescale 1ns / 1ps
// Work vector, chain value and a shared half-round unit of four G functions.
module b2b_datapath (
    input  logic              i_clk,
    input  b2b_pkg::t_dp_ctrl i_ctrl,
    input  logic [6:0]        i_len,
    input  logic [63:0]       i_m [16],
    input  logic [127:0]      i_count,
    output logic [63:0]       o_h [8]
);
    logic [63:0] r_v [16];
    logic [63:0] r_h [8];
    logic [63:0] g_out [4][4];
    logic [3:0]  idx [4][4];

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            idx[g][0] = 4'(g);
            idx[g][1] = i_ctrl.diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
            idx[g][2] = i_ctrl.diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
            idx[g][3] = i_ctrl.diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
        end
    end

    always_comb begin
        logic [63:0] a, b, c, d, x, y;
        logic [3:0]  j;
        for (int g = 0; g < 4; g++) begin
            j = 4'(2 * g) + (i_ctrl.diag ? 4'd8 : 4'd0);
            x = i_m[b2b_pkg::sigma_at(i_ctrl.round, j)];
            y = i_m[b2b_pkg::sigma_at(i_ctrl.round, j + 4'd1)];
            a = r_v[idx[g][0]]; b = r_v[idx[g][1]];
            c = r_v[idx[g][2]]; d = r_v[idx[g][3]];
            a = a + b + x; d = rotr(d ^ a, 32);
            c = c + d;     b = rotr(b ^ c, 24);
            a = a + b + y; d = rotr(d ^ a, 16);
            c = c + d;     b = rotr(b ^ c, 63);
            g_out[g][0] = a; g_out[g][1] = b; g_out[g][2] = c; g_out[g][3] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            b2b_pkg::CMD_INIT: begin
                for (int i = 1; i < 8; i++) r_h[i] <= b2b_pkg::IV[i];
                r_h[0] <= b2b_pkg::IV[0] ^ {32'd0, b2b_pkg::PARAM_WORD | {25'd0,
                    b2b_pkg::eff_len(i_len)}};
            end
            b2b_pkg::CMD_LOAD: begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                for (int i = 0; i < 4; i++) r_v[i + 8] <= b2b_pkg::IV[i];
                r_v[12] <= b2b_pkg::IV[4] ^ i_count[63:0];
                r_v[13] <= b2b_pkg::IV[5] ^ i_count[127:64];
                r_v[14] <= b2b_pkg::IV[6] ^ {64{i_ctrl.final_blk}};
                r_v[15] <= b2b_pkg::IV[7];
            end
            b2b_pkg::CMD_STEP: begin
                if (i_ctrl.finish) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                end else begin
                    for (int g = 0; g < 4; g++)
                        for (int k = 0; k < 4; k++)
                            r_v[idx[g][k]] <= g_out[g][k];
                end
            end
            default: ;
        endcase
    end

    assign o_h = r_h;
endmodule

[rtl/b2b_control.sv]
`timescale 1ns / 1ps
// Sequencer: block gathering, compression rounds and digest output.
module b2b_control (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_message_word,
    input  logic [3:0]        i_byte_count,
    input  logic              i_last_word,
    input  logic              i_cfg_write,
    input  logic [6:0]        i_len,
    input  logic [63:0]       i_h [8],
    output logic              o_busy,
    output b2b_pkg::t_dp_ctrl o_ctrl,
    output logic [63:0]       o_m [16],
    output logic [127:0]      o_count,
    output logic              o_valid,
    output logic [63:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_out
);
    typedef enum logic [2:0] {S_INIT, S_IDLE, S_LOAD, S_RUN, S_FOLD, S_OUT} t_state;

    t_state      r_state;
    logic [63:0] r_m [16];
    logic [4:0]  r_fill;
    logic [127:0] r_count;
    logic [4:0]  r_step;
    logic        r_final, r_pend;
    logic [63:0] r_pw;
    logic [3:0]  r_pc;
    logic        r_pl;
    logic [2:0]  r_k;
    logic        r_valid;
    logic [63:0] r_dw;
    logic [2:0]  r_wi;
    logic        r_lo;

    logic [3:0]  cnt;
    logic [63:0] word;
    logic [2:0]  nlast;
    logic [6:0]  len;
    logic [6:0]  rem;
    logic [63:0] dword;

    always_comb begin
        cnt = i_last_word ? ((i_byte_count > 4'd8) ? 4'd8 : i_byte_count) : 4'd8;
        word = i_message_word;
        for (int b = 0; b < 8; b++) if (4'(b) >= cnt) word[b*8 +: 8] = 8'd0;
        len = b2b_pkg::eff_len(i_len);
        nlast = 3'((len - 7'd1) >> 3);
        rem = len - {1'b0, r_k, 3'd0};
        dword = i_h[r_k];
        for (int b = 0; b < 8; b++)
            if (rem < 7'd8 && 7'(b) >= rem) dword[b*8 +: 8] = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_write) begin
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_fill  <= '0;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_start) begin
                            r_pw <= word; r_pc <= cnt; r_pl <= i_last_word;
                            if (!i_last_word || cnt != 4'd0) begin
                                if (r_fill == 5'(b2b_pkg::BLOCK_WORDS)) begin
                                    r_final <= 1'b0; r_pend <= 1'b1;
                                    r_state <= S_LOAD;
                                end else begin
                                    r_m[r_fill[3:0]] <= word;
                                    r_fill <= r_fill + 5'd1;
                                    r_count <= r_count + 128'(cnt);
                                    if (i_last_word) begin
                                        for (int i = 0; i < 16; i++)
                                            if (5'(i) > r_fill) r_m[i] <= '0;
                                        r_final <= 1'b1; r_pend <= 1'b0;
                                        r_state <= S_LOAD;
                                    end
                                end
                            end else begin
                                for (int i = 0; i < 16; i++)
                                    if (5'(i) >= r_fill) r_m[i] <= '0;
                                r_final <= 1'b1; r_pend <= 1'b0;
                                r_state <= S_LOAD;
                            end
                        end
                    end
                    S_LOAD: begin
                        r_step <= '0;
                        r_state <= S_RUN;
                    end
                    S_RUN: begin
                        r_step <= r_step + 5'd1;
                        if (r_step == 5'(2 * b2b_pkg::ROUND_COUNT - 1)) r_state <= S_FOLD;
                    end
                    S_FOLD: begin
                        r_k <= '0;
                        if (r_pend) begin
                            r_pend <= 1'b0;
                            r_m[0] <= r_pw;
                            r_fill <= 5'd1;
                            r_count <= r_count + 128'(r_pc);
                            if (r_pl) begin
                                for (int i = 1; i < 16; i++) r_m[i] <= '0;
                                r_final <= 1'b1;
                                r_state <= S_LOAD;
                            end else r_state <= S_IDLE;
                        end else if (r_final) r_state <= S_OUT;
                        else r_state <= S_IDLE;
                    end
                    S_OUT: begin
                        r_valid <= 1'b1;
                        r_wi <= r_k;
                        r_lo <= (r_k == nlast);
                        r_dw <= dword;
                        r_k <= r_k + 3'd1;
                        if (r_k == nlast) r_state <= S_INIT;
                    end
                    default: r_state <= S_INIT;
                endcase
            end
        end
    end

    always_comb begin
        o_ctrl.cmd = b2b_pkg::CMD_NONE;
        if (r_state == S_INIT) o_ctrl.cmd = b2b_pkg::CMD_INIT;
        if (r_state == S_LOAD) o_ctrl.cmd = b2b_pkg::CMD_LOAD;
        if (r_state == S_RUN || r_state == S_FOLD) o_ctrl.cmd = b2b_pkg::CMD_STEP;
        o_ctrl.final_blk = r_final;
        o_ctrl.round = 4'(r_step >> 1);
        o_ctrl.diag = r_step[0];
        o_ctrl.finish = (r_state == S_FOLD);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_m = r_m;
    assign o_count = r_count;
    assign o_valid = r_valid;
    assign o_digest_word = r_dw;
    assign o_word_index = r_wi;
    assign o_last_out = r_lo;
endmodule

[rtl/blake2b_unkeyed_hash_core.sv]
`timescale 1ns / 1ps
// Unkeyed BLAKE2b core. Message words enter when start is high and busy is
// low; a result strobe marks each digest beat, which the receiver must take
// in that cycle because it cannot stall the core. A word that only joins the
// held block leaves busy low, so such words can follow back to back.
// A word that arrives on a full held block raises busy, which stays high
// through load, 24 half-rounds of the shared four-G unit and fold. A final
// word runs one compression (two when it lands on a full block), then emits
// one digest beat per cycle and reloads the chain value in its init state
// before busy drops. After reset or a configuration write the core likewise
// reloads its chain value before it takes a beat.
module blake2b_unkeyed_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_digest_bytes,
    output logic        o_valid,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_out
);
    logic [6:0]        r_len;
    logic              cfg_write;
    b2b_pkg::t_dp_ctrl ctrl;
    logic [63:0]       m [16];
    logic [127:0]      count;
    logic [63:0]       h [8];
    logic              ctl_busy;

    // Configuration is taken whenever offered; the core restarts its message.
    assign o_cfg_ready = 1'b1;
    assign cfg_write = i_cfg_valid;
    assign busy = ctl_busy || cfg_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= 7'd64;
        else if (cfg_write) r_len <= i_cfg_digest_bytes;
    end

    b2b_control u_ctl (
        .i_clk, .i_rst_n, .i_start(start), .i_message_word, .i_byte_count,
        .i_last_word, .i_cfg_write(cfg_write), .i_len(r_len), .i_h(h),
        .o_busy(ctl_busy), .o_ctrl(ctrl), .o_m(m), .o_count(count),
        .o_valid, .o_digest_word, .o_word_index, .o_last_out
    );

    b2b_datapath u_dp (
        .i_clk, .i_ctrl(ctrl), .i_len(r_len), .i_m(m), .i_count(count), .o_h(h)
    );
endmodule

[rtl/b2b_checker.sv]
`timescale 1ns / 1ps
`include "blake2b_unkeyed_hash_core_defines.svh"
module b2b_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       start,
    input logic       i_last_word,
    input logic       o_valid,
    input logic [2:0] o_word_index,
    input logic       o_last_out
);
    `B2B_ASSERT(a_busy_after_last, i_clk, i_rst_n, (start && !busy && i_last_word) |=> busy, "idle after last")
    `B2B_ASSERT(a_out_busy, i_clk, i_rst_n, o_valid |-> busy || $past(busy), "beat while idle")
    `B2B_ASSERT(a_index_seq, i_clk, i_rst_n, (o_valid && !o_last_out) |=> (o_valid && o_word_index == $past(o_word_index) + 3'd1), "beats not consecutive")
    `B2B_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "beat after reset")
endmodule

bind blake2b_unkeyed_hash_core b2b_checker u_chk (
    .i_clk, .i_rst_n, .busy, .start, .i_last_word, .o_valid, .o_word_index, .o_last_out
);

[tb/blake2b_unkeyed_hash_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the unkeyed BLAKE2b core. Message words are
// queued by the stimulus process and handed to the core by a clocked
// driver. Each accepted beat also runs through a behavioral hash model
// kept in this module, and the model pushes the digest words that the
// core must return. A clocked monitor takes every result beat and
// compares it field by field with the oldest expected digest word.
module blake2b_unkeyed_hash_core_tb;
    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
    } msg_beat_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam int WATCHDOG_LIMIT = 4000;
    // Longest quiet stretch after the last result: a full compression
    // plus a digest burst, with margin.
    localparam int SETTLE_CYCLES = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_message_word;
    logic [3:0]  i_byte_count;
    logic        i_last_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_digest_bytes;
    logic        o_valid;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_out;

    blake2b_unkeyed_hash_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_message_word     (i_message_word),
        .i_byte_count       (i_byte_count),
        .i_last_word        (i_last_word),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_digest_bytes (i_cfg_digest_bytes),
        .o_valid            (o_valid),
        .o_digest_word      (o_digest_word),
        .o_word_index       (o_word_index),
        .o_last_out         (o_last_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash model state.
    // ------------------------------------------------------------------
    logic [63:0] hash_iv [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    int msg_sched [10][16] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{ 7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{ 9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{ 2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{ 6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
    };

    logic [6:0]  digest_len_reg;
    logic [63:0] chain_h [8];
    logic [63:0] bytes_lo, bytes_hi;
    logic [63:0] block_buf [16];
    logic [63:0] mix_v [16];
    int          words_held;

    msg_beat_t    msg_q [$];
    digest_beat_t digest_q [$];
    int           mismatch_cnt;

    function automatic int digest_len();
        if (digest_len_reg == 7'd0) return 1;
        if (digest_len_reg > 7'd64) return 64;
        return int'(digest_len_reg);
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) chain_h[i] = hash_iv[i];
        chain_h[0] ^= 64'h01010000 | 64'(digest_len());
        bytes_lo   = '0;
        bytes_hi   = '0;
        words_held = 0;
    endfunction

    function automatic logic [63:0] rotr64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void g_mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
        mix_v[a] = mix_v[a] + mix_v[b] + x;
        mix_v[d] = rotr64(mix_v[d] ^ mix_v[a], 32);
        mix_v[c] = mix_v[c] + mix_v[d];
        mix_v[b] = rotr64(mix_v[b] ^ mix_v[c], 24);
        mix_v[a] = mix_v[a] + mix_v[b] + y;
        mix_v[d] = rotr64(mix_v[d] ^ mix_v[a], 16);
        mix_v[c] = mix_v[c] + mix_v[d];
        mix_v[b] = rotr64(mix_v[b] ^ mix_v[c], 63);
    endfunction

    function automatic void compress_block(bit is_final);
        int s;
        for (int i = 0; i < 8; i++) begin
            mix_v[i]     = chain_h[i];
            mix_v[i + 8] = hash_iv[i];
        end
        mix_v[12] ^= bytes_lo;
        mix_v[13] ^= bytes_hi;
        if (is_final) mix_v[14] = ~mix_v[14];
        for (int r = 0; r < 12; r++) begin
            s = r % 10;
            g_mix(0, 4, 8, 12, block_buf[msg_sched[s][0]], block_buf[msg_sched[s][1]]);
            g_mix(1, 5, 9, 13, block_buf[msg_sched[s][2]], block_buf[msg_sched[s][3]]);
            g_mix(2, 6, 10, 14, block_buf[msg_sched[s][4]], block_buf[msg_sched[s][5]]);
            g_mix(3, 7, 11, 15, block_buf[msg_sched[s][6]], block_buf[msg_sched[s][7]]);
            g_mix(0, 5, 10, 15, block_buf[msg_sched[s][8]], block_buf[msg_sched[s][9]]);
            g_mix(1, 6, 11, 12, block_buf[msg_sched[s][10]], block_buf[msg_sched[s][11]]);
            g_mix(2, 7, 8, 13, block_buf[msg_sched[s][12]], block_buf[msg_sched[s][13]]);
            g_mix(3, 4, 9, 14, block_buf[msg_sched[s][14]], block_buf[msg_sched[s][15]]);
        end
        for (int i = 0; i < 8; i++) chain_h[i] ^= mix_v[i] ^ mix_v[i + 8];
    endfunction

    // Absorbs one accepted beat; on the last word of a message it queues
    // the digest words the core must return.
    function automatic void absorb_beat(msg_beat_t b);
        logic [63:0]  w;
        int           n, len, nwords, rem;
        digest_beat_t d;
        w = b.word;
        n = b.last ? int'(b.cnt) : 8;
        if (n > 8) n = 8;
        if (n < 8) w &= (64'd1 << (8 * n)) - 64'd1;
        if (!b.last || n != 0) begin
            // A full block is only compressed once more data shows up.
            if (words_held >= 16) begin
                compress_block(1'b0);
                words_held = 0;
            end
            block_buf[words_held] = w;
            words_held++;
            bytes_lo += 64'(n);
            if (bytes_lo < 64'(n)) bytes_hi += 64'd1;
        end
        if (!b.last) return;
        for (int i = words_held; i < 16; i++) block_buf[i] = '0;
        compress_block(1'b1);
        len    = digest_len();
        nwords = (len + 7) / 8;
        for (int k = 0; k < nwords; k++) begin
            d.word = chain_h[k];
            d.idx  = 3'(k);
            d.last = (k + 1 == nwords);
            rem    = len - 8 * k;
            if (d.last && rem < 8) d.word &= (64'd1 << (8 * rem)) - 64'd1;
            digest_q.push_back(d);
        end
        restart_hash();
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued beats, with random gaps between them.
    // ------------------------------------------------------------------
    int        gap_left;
    msg_beat_t cur_beat;
    logic      beat_taken;
    logic      result_taken;
    logic      cfg_taken;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
            start      <= 1'b0;
            gap_left = 0;
        end else begin
            beat_taken <= start && !busy;
            if (start && !busy) begin
                absorb_beat(cur_beat);
                gap_left = pick_gap();
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (msg_q.size() > 0) begin
                    cur_beat = msg_q.pop_front();
                    i_message_word <= cur_beat.word;
                    i_byte_count   <= cur_beat.cnt;
                    i_last_word    <= cur_beat.last;
                    start          <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog.
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge i_clk) begin
        digest_beat_t exp_d;
        if (i_rst_n && o_valid) begin
            if (digest_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected digest beat: word=%h idx=%0d last=%b",
                             o_digest_word, o_word_index, o_last_out);
            end else begin
                exp_d = digest_q.pop_front();
                if (o_digest_word !== exp_d.word || o_word_index !== exp_d.idx ||
                    o_last_out !== exp_d.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_d.word, exp_d.idx, exp_d.last,
                                 o_digest_word, o_word_index, o_last_out);
                end
            end
        end
        if (!i_rst_n || beat_taken || o_valid || cfg_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[blake2b_unkeyed_hash_core] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic add_beat(logic [63:0] w, logic [3:0] c, logic l);
        msg_beat_t b;
        b.word = w;
        b.cnt  = c;
        b.last = l;
        msg_q.push_back(b);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // A message of nwords beats with random content; non-last beats carry
    // random counts since the core must treat them all as full words.
    task automatic add_message(int nwords);
        for (int i = 0; i < nwords - 1; i++)
            add_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        add_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b1);
    endtask

    task automatic wait_drained();
        while (msg_q.size() > 0 || start || digest_q.size() > 0) @(posedge i_clk);
    endtask

    // Length changes only happen with the core idle. A trailing non-last
    // beat can still be compressing after the queues drain, so we settle.
    task automatic write_digest_len(logic [6:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_digest_bytes <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        // The write lands at this edge.
        digest_len_reg = v;
        restart_hash();
        cfg_taken   <= 1'b1;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_taken <= 1'b0;
    endtask

    logic [6:0] len_plan [8] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd33, 7'd8, 7'd20, 7'd64};

    initial begin
        int roll;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_message_word     = '0;
        i_byte_count       = '0;
        i_last_word        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_digest_bytes = 7'd64;
        beat_taken         = 1'b0;
        cfg_taken          = 1'b0;
        mismatch_cnt       = 0;
        quiet_cycles       = 0;
        digest_len_reg     = 7'd64;
        for (int i = 0; i < 16; i++) block_buf[i] = '0;
        restart_hash();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset digest length.
        add_beat('0, 4'd0, 1'b1);                          // empty message
        add_beat('1, 4'd8, 1'b1);                          // one full word
        add_beat('1, 4'd15, 1'b1);                         // oversized count
        add_beat(64'h0123456789abcdef, 4'd3, 1'b0);        // count ignored on non-last
        add_beat('1, 4'd5, 1'b1);                          // unused bytes cleared
        for (int i = 0; i < 15; i++) add_beat(rand_word(), 4'd8, 1'b0);
        add_beat('1, 4'd8, 1'b1);                          // exactly one block
        wait_drained();
        for (int i = 0; i < 16; i++) add_beat(rand_word(), 4'd8, 1'b0);
        add_beat(rand_word(), 4'd0, 1'b1);                 // empty last after full block

        // Random part: one phase per planned digest length, extremes first.
        for (int ph = 0; ph < 8; ph++) begin
            write_digest_len(len_plan[ph]);
            for (int m = 0; m < 4; m++) begin
                roll = $urandom_range(0, 9);
                if (roll < 6)      add_message($urandom_range(1, 4));
                else if (roll < 9) add_message($urandom_range(5, 17));
                else               add_message($urandom_range(30, 34));
            end
            // Occasionally leave a message open; the length write drops it.
            if ($urandom_range(0, 3) == 0) add_beat(rand_word(), 4'd8, 1'b0);
            if (ph % 4 == 1) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && digest_q.size() == 0) begin
            $display("[blake2b_unkeyed_hash_core] OK");
        end else begin
            $display("[blake2b_unkeyed_hash_core] ERROR");
        end
        $finish;
    end
endmodule
